// ===== hw/rtl/kdar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdar_pkg
// Shared types, register map and helpers for the key debounce block.
// ----------------------------------------------------------------------------
package kdar_pkg;

    localparam int TimeW  = 32;
    localparam int MsW    = 16;
    localparam int KeyW   = 4;
    localparam int ActW   = 3;
    localparam int AddrW  = 4;
    localparam int DataW  = 32;

    localparam logic [MsW-1:0] DebounceRst    = 16'd12;
    localparam logic [MsW-1:0] RepeatDelayRst = 16'd180;
    localparam logic [MsW-1:0] RepeatRateRst  = 16'd55;

    typedef enum logic [ActW-1:0] {
        KEY_NONE   = 3'd0,
        KEY_PREV   = 3'd1,
        KEY_NEXT   = 3'd2,
        KEY_SELECT = 3'd3,
        KEY_BACK   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        REG_DEBOUNCE     = 2'd0,
        REG_REPEAT_DELAY = 2'd1,
        REG_REPEAT_RATE  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [MsW-1:0] db_ms;
        logic [MsW-1:0] delay_ms;
        logic [MsW-1:0] rate_ms;
    } cfg_t;

    // lowest set bit wins: up, down, select, back
    function automatic action_t encode_pressed(input logic [KeyW-1:0] bits);
        action_t act;
        if (bits[0])
        begin
            act = KEY_PREV;
        end
        else if (bits[1])
        begin
            act = KEY_NEXT;
        end
        else if (bits[2])
        begin
            act = KEY_SELECT;
        end
        else if (bits[3])
        begin
            act = KEY_BACK;
        end
        else
        begin
            act = KEY_NONE;
        end
        return act;
    endfunction

endpackage

// ===== hw/rtl/kdar_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdar_cfg
// APB register file holding the debounce and repeat timing settings.
// ----------------------------------------------------------------------------
module kdar_cfg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kdar_pkg::AddrW-1:0] paddr,
    input  logic [kdar_pkg::DataW-1:0] pwdata,
    output logic [kdar_pkg::DataW-1:0] prdata,
    output logic                       pready,
    output kdar_pkg::cfg_t             cfg
);
    import kdar_pkg::*;

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
    assign cfg    = cfg_reg;

    // register writes, unmapped index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.db_ms    <= DebounceRst;
            cfg_reg.delay_ms <= RepeatDelayRst;
            cfg_reg.rate_ms  <= RepeatRateRst;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_DEBOUNCE:     cfg_reg.db_ms    <= pwdata[MsW-1:0];
                REG_REPEAT_DELAY: cfg_reg.delay_ms <= pwdata[MsW-1:0];
                REG_REPEAT_RATE:  cfg_reg.rate_ms  <= pwdata[MsW-1:0];
                default:          ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_DEBOUNCE:     prdata = {{(DataW-MsW){1'b0}}, cfg_reg.db_ms};
            REG_REPEAT_DELAY: prdata = {{(DataW-MsW){1'b0}}, cfg_reg.delay_ms};
            REG_REPEAT_RATE:  prdata = {{(DataW-MsW){1'b0}}, cfg_reg.rate_ms};
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/kdar_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdar_core
// Debounce and auto-repeat decision with its timing state, one poll per cycle while en is high.
// ----------------------------------------------------------------------------
module kdar_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [kdar_pkg::TimeW-1:0]  now_ms,
    input  logic [kdar_pkg::KeyW-1:0]   pressed,
    input  kdar_pkg::cfg_t              cfg,
    output kdar_pkg::action_t           action
);
    import kdar_pkg::*;

    action_t           stable_reg,      stable_next;
    logic [TimeW-1:0]  last_change_reg, last_change_next;
    logic [TimeW-1:0]  press_start_reg, press_start_next;
    logic [TimeW-1:0]  last_rep_reg,    last_rep_next;

    action_t           raw;
    logic [TimeW-1:0]  dt_change;
    logic [TimeW-1:0]  dt_press;
    logic [TimeW-1:0]  dt_rep;
    logic              debounce_ok;
    logic              repeat_due;

    // raw action and wrapped time differences
    assign raw         = encode_pressed(pressed);
    assign dt_change   = now_ms - last_change_reg;
    assign dt_press    = now_ms - press_start_reg;
    assign dt_rep      = now_ms - last_rep_reg;
    assign debounce_ok = dt_change >= {{(TimeW-MsW){1'b0}}, cfg.db_ms};
    assign repeat_due  = (dt_press >= {{(TimeW-MsW){1'b0}}, cfg.delay_ms}) &&
                         (dt_rep   >= {{(TimeW-MsW){1'b0}}, cfg.rate_ms});

    // next state and reported action
    always_comb
    begin
        stable_next      = stable_reg;
        last_change_next = last_change_reg;
        press_start_next = press_start_reg;
        last_rep_next    = last_rep_reg;
        action           = KEY_NONE;
        if (raw != stable_reg)
        begin
            if (debounce_ok)
            begin
                stable_next      = raw;
                last_change_next = now_ms;
                if (raw != KEY_NONE)
                begin
                    press_start_next = now_ms;
                    last_rep_next    = now_ms;
                    action           = raw;
                end
                else
                begin
                    press_start_next = '0;
                    last_rep_next    = '0;
                end
            end
        end
        else if ((stable_reg == KEY_PREV || stable_reg == KEY_NEXT) && repeat_due)
        begin
            last_rep_next = now_ms;
            action        = stable_reg;
        end
    end

    // state update, only on a poll that moves to the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg      <= KEY_NONE;
            last_change_reg <= '0;
            press_start_reg <= '0;
            last_rep_reg    <= '0;
        end
        else if (en)
        begin
            stable_reg      <= stable_next;
            last_change_reg <= last_change_next;
            press_start_reg <= press_start_next;
            last_rep_reg    <= last_rep_next;
        end
    end

`ifndef SYNTHESIS
    // released key leaves the repeat timers cleared
    a_idle_timers_clear: assert property (@(posedge clk) disable iff (!rst_n)
        stable_reg == KEY_NONE |-> press_start_reg == '0 && last_rep_reg == '0)
        else $error("timers not cleared while no key is stable");

    // repeat timer never runs ahead of the press start on a new press
    a_press_sets_timers: assert property (@(posedge clk) disable iff (!rst_n)
        en && raw != stable_reg && debounce_ok && raw != KEY_NONE |=>
        press_start_reg == last_rep_reg && last_change_reg == press_start_reg)
        else $error("new press did not restart timers");

    // state frozen when no poll advances
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(stable_reg) && $stable(last_change_reg))
        else $error("state changed without a poll");
`endif

endmodule

// ===== hw/rtl/key_debounce_auto_repeat.sv =====
`timescale 1ns / 1ps
// A poll is held in the input register and its action is registered in the result register.
// Throughput: one poll per cycle while in_stall is low; the state update from input register
//   to result register is a single pass of three 32-bit subtract-compares and a priority encoder.
// Reset: rst_n is asynchronous and active low; timing registers return to 12, 180 and 55 ms,
//   the stable action to none and all timestamps to zero; both stages empty.
// ----------------------------------------------------------------------------
// key_debounce_auto_repeat
// Button debounce with auto-repeat for prev and next, APB-configured timing.
// ----------------------------------------------------------------------------
module key_debounce_auto_repeat
(
    input  logic                       clk,
    input  logic                       rst_n,
    // poll requests
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [kdar_pkg::TimeW-1:0] now_ms,
    input  logic [kdar_pkg::KeyW-1:0]  pressed,
    // action results
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [kdar_pkg::ActW-1:0]  action,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kdar_pkg::AddrW-1:0] paddr,
    input  logic [kdar_pkg::DataW-1:0] pwdata,
    output logic [kdar_pkg::DataW-1:0] prdata,
    output logic                       pready
);
    import kdar_pkg::*;

    cfg_t             cfg;
    logic             in_full_reg, in_full_next;
    logic [TimeW-1:0] now_reg;
    logic [KeyW-1:0]  pressed_reg;
    logic             out_valid_reg, out_valid_next;
    action_t          action_reg;
    action_t          core_action;
    logic             advance;
    logic             in_take;

    kdar_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kdar_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (advance),
        .now_ms  (now_reg),
        .pressed (pressed_reg),
        .cfg     (cfg),
        .action  (core_action)
    );

    // handshake between the two stages
    assign advance        = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = in_full_reg && !advance;
    assign in_take        = in_valid && !in_stall;
    assign in_full_next   = in_take || (in_full_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input payload register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            now_reg     <= now_ms;
            pressed_reg <= pressed;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            action_reg <= core_action;
        end
    end

    assign out_valid = out_valid_reg;
    assign action    = action_reg;

`ifndef SYNTHESIS
    // a poll leaving the input register always lands in the result register
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register empty after advance");

    // stall only with a held poll that cannot move on
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_full_reg && out_valid_reg && out_stall)
        else $error("input stalled without backpressure");

    // reported action is always a defined code
    a_action_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> action_reg == KEY_NONE || action_reg == KEY_PREV ||
        action_reg == KEY_NEXT || action_reg == KEY_SELECT || action_reg == KEY_BACK)
        else $error("illegal action code");
`endif

endmodule
